// ===== design/imu_bias_calibrate_and_scale_defines.svh =====
// ---------------------------------------------------------------------------
// imu_bias_calibrate_and_scale_defines.svh
// Assertion macros shared by the IMU bias calibration block.
// ---------------------------------------------------------------------------
`ifndef IMU_BIAS_CALIBRATE_AND_SCALE_DEFINES_SVH
`define IMU_BIAS_CALIBRATE_AND_SCALE_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define IBCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge.
`define IBCS_ASSERT_NEVER(label, cond, msg) \
    `IBCS_ASSERT(label, !(cond), msg)

`endif

// ===== design/ibcs_pkg.sv =====
// ---------------------------------------------------------------------------
// ibcs_pkg
// Types, codes and constants of the IMU bias calibration and scaling block.
// ---------------------------------------------------------------------------
package ibcs_pkg;

    localparam int AXES        = 6;
    localparam int SAMPLE_W    = 16;
    localparam int BIAS_W      = 17;
    localparam int CORR_W      = 18;
    localparam int RES_W       = 28;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam int DEF_SKIP_SAMPLES = 101;
    localparam int DEF_CAL_SAMPLES  = 1000;
    localparam int DEF_QUEUE_DEPTH  = 4;

    // One g at the 2g range, in counts
    localparam logic signed [BIAS_W-1:0] ONE_G_COUNTS = BIAS_W'(16384);
    // Gyro LSB scale in Q.15 deg/s at the 250 deg/s range
    localparam logic signed [RES_W-1:0]  GYRO_DPS_LSB = RES_W'(250);

    typedef enum logic [1:0] {
        ACT_CONVERT   = 2'd0,
        ACT_CALIBRATE = 2'd1,
        ACT_LOAD      = 2'd2,
        ACT_READ      = 2'd3
    } action_t;

    localparam logic [1:0] FORM_RAW       = 2'd0;
    localparam logic [1:0] FORM_CORRECTED = 2'd1;
    localparam logic [1:0] FORM_SCALED    = 2'd2;

    localparam logic [1:0] REG_ACCEL_RANGE = 2'd0;
    localparam logic [1:0] REG_GYRO_RANGE  = 2'd1;
    localparam logic [1:0] REG_OUTPUT_FORM = 2'd2;

    typedef struct packed {
        action_t                     action;
        logic signed [SAMPLE_W-1:0]  accel_x;
        logic signed [SAMPLE_W-1:0]  accel_y;
        logic signed [SAMPLE_W-1:0]  accel_z;
        logic signed [SAMPLE_W-1:0]  gyro_x;
        logic signed [SAMPLE_W-1:0]  gyro_y;
        logic signed [SAMPLE_W-1:0]  gyro_z;
    } sample_t;

    typedef struct packed {
        logic signed [RES_W-1:0] out_accel_x;
        logic signed [RES_W-1:0] out_accel_y;
        logic signed [RES_W-1:0] out_accel_z;
        logic signed [RES_W-1:0] out_gyro_x;
        logic signed [RES_W-1:0] out_gyro_y;
        logic signed [RES_W-1:0] out_gyro_z;
        logic                    cal_done;
        logic                    cal_active;
    } result_t;

    // Classified item as it sits in the queue
    typedef struct packed {
        sample_t sample;
        logic    accumulate;    // calibration sample past the skip window
        logic    finish;        // calibration sample that closes the run
        logic    active_after;  // run still in progress after this item
    } entry_t;

    // Back end status
    typedef struct packed {
        logic pop;
        logic busy;
        logic div_done;
    } back_stat_t;

endpackage

// ===== design/ibcs_front.sv =====
// ---------------------------------------------------------------------------
// ibcs_front
// Accepts samples, tracks the calibration count and classifies each item.
// ---------------------------------------------------------------------------
module ibcs_front #(
    parameter int SKIP_SAMPLES = ibcs_pkg::DEF_SKIP_SAMPLES,
    parameter int CAL_SAMPLES  = ibcs_pkg::DEF_CAL_SAMPLES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ibcs_pkg::sample_t s_data,
    input  logic              q_not_full,
    output logic              q_wr_en,
    output ibcs_pkg::entry_t  q_wr_data
);

    localparam int CNT_W = (SKIP_SAMPLES + CAL_SAMPLES > 1) ?
                           $clog2(SKIP_SAMPLES + CAL_SAMPLES) : 1;
    localparam logic [CNT_W-1:0] SKIP_CNT = CNT_W'(SKIP_SAMPLES);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SKIP_SAMPLES + CAL_SAMPLES - 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_step;
    logic             is_cal, in_window, closing;

    assign s_ready = q_not_full;
    assign q_wr_en = s_valid && q_not_full;

    always_comb begin
        is_cal    = (s_data.action == ibcs_pkg::ACT_CALIBRATE);
        in_window = (cnt_reg >= SKIP_CNT);
        closing   = (cnt_reg >= LAST_CNT);
        cnt_step  = closing ? '0 : cnt_reg + CNT_W'(1);
        cnt_next  = cnt_reg;
        if (q_wr_en && is_cal) begin
            cnt_next = cnt_step;
        end

        q_wr_data.sample       = s_data;
        q_wr_data.accumulate   = is_cal && in_window;
        q_wr_data.finish       = is_cal && closing;
        q_wr_data.active_after = is_cal ? (cnt_step != '0) : (cnt_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/ibcs_queue.sv =====
// ---------------------------------------------------------------------------
// ibcs_queue
// Short FIFO between the classifying front end and the back end.
// ---------------------------------------------------------------------------
module ibcs_queue #(
    parameter int DEPTH = ibcs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  ibcs_pkg::entry_t wr_data,
    output logic             not_full,
    input  logic             rd_en,
    output logic             rd_valid,
    output ibcs_pkg::entry_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ibcs_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign not_full = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        do_wr       = wr_en && not_full;
        do_rd       = rd_en && rd_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/ibcs_divider.sv =====
// ---------------------------------------------------------------------------
// ibcs_divider
// Six lanes dividing the calibration sums by the sample count through a
// reciprocal multiply, truncating toward zero; the quotient is valid with done.
// ---------------------------------------------------------------------------
module ibcs_divider #(
    parameter int CAL_SAMPLES = ibcs_pkg::DEF_CAL_SAMPLES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [ibcs_pkg::SAMPLE_W+$clog2(CAL_SAMPLES)-1:0]
                                                dividend [ibcs_pkg::AXES],
    output logic                                done,
    output logic signed [ibcs_pkg::BIAS_W-1:0]  quotient [ibcs_pkg::AXES]
);

    localparam int SUM_W  = ibcs_pkg::SAMPLE_W + $clog2(CAL_SAMPLES);
    localparam int MAG_W  = SUM_W;
    localparam int SHIFT  = MAG_W + $clog2(CAL_SAMPLES);
    localparam int PROD_W = 2 * MAG_W + 1;
    // ceil(2^SHIFT / CAL_SAMPLES): floor(mag * RECIP >> SHIFT) is exact
    // for every MAG_W-bit magnitude
    localparam logic [MAG_W:0] RECIP = (MAG_W + 1)'(
        ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    logic [MAG_W-1:0]            mag_reg  [ibcs_pkg::AXES];
    logic [PROD_W-1:0]           prod_reg [ibcs_pkg::AXES];
    logic [ibcs_pkg::AXES-1:0]   neg_reg;
    logic                        mul_reg;
    logic                        done_reg;
    logic [ibcs_pkg::BIAS_W-1:0] qmag     [ibcs_pkg::AXES];

    assign done = done_reg;

    always_comb begin
        for (int i = 0; i < ibcs_pkg::AXES; i++) begin
            qmag[i]     = prod_reg[i][SHIFT +: ibcs_pkg::BIAS_W];
            quotient[i] = neg_reg[i] ? signed'(~qmag[i] + ibcs_pkg::BIAS_W'(1))
                                     : signed'(qmag[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg  <= start;
            done_reg <= mul_reg;
        end
    end

    // stage 1: sign and magnitude; stage 2: magnitude times reciprocal
    // (26 x 27 significant bits at the default count)
    always_ff @(posedge aclk) begin
        for (int i = 0; i < ibcs_pkg::AXES; i++) begin
            if (start) begin
                neg_reg[i] <= dividend[i][SUM_W-1];
                mag_reg[i] <= dividend[i][SUM_W-1] ? MAG_W'(-dividend[i])
                                                   : MAG_W'(dividend[i]);
            end
            if (mul_reg) begin
                prod_reg[i] <= PROD_W'(mag_reg[i]) * PROD_W'(RECIP);
            end
        end
    end

endmodule

// ===== design/ibcs_back.sv =====
// ---------------------------------------------------------------------------
// ibcs_back
// Executes queued items: conversion, calibration sums, bias update and the
// output register.
// ---------------------------------------------------------------------------
module ibcs_back #(
    parameter int CAL_SAMPLES = ibcs_pkg::DEF_CAL_SAMPLES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           accel_range,
    input  logic [1:0]           gyro_range,
    input  logic [1:0]           output_form,
    input  logic                 head_valid,
    input  ibcs_pkg::entry_t     head,
    output ibcs_pkg::back_stat_t stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ibcs_pkg::result_t    m_data
);

    localparam int AXES   = ibcs_pkg::AXES;
    localparam int SUM_W  = 16 + $clog2(CAL_SAMPLES);
    localparam int BIAS_W = ibcs_pkg::BIAS_W;
    localparam int CORR_W = ibcs_pkg::CORR_W;
    localparam int RES_W  = ibcs_pkg::RES_W;

    logic signed [SUM_W-1:0]           sum_reg  [AXES];
    logic signed [SUM_W-1:0]           sum_next [AXES];
    logic signed [SUM_W-1:0]           sum_acc  [AXES];
    logic signed [BIAS_W-1:0]          bias_reg [AXES];
    logic signed [BIAS_W-1:0]          bias_next[AXES];
    logic signed [BIAS_W-1:0]          quot     [AXES];
    logic signed [ibcs_pkg::SAMPLE_W-1:0] samp  [AXES];
    logic signed [CORR_W-1:0]          corr     [AXES];
    logic signed [RES_W-1:0]           conv     [AXES];
    logic signed [RES_W-1:0]           res_val  [AXES];

    logic                busy_reg, busy_next;
    logic                m_valid_reg, m_valid_next;
    ibcs_pkg::result_t   m_data_reg, m_data_next;
    logic                pop, div_start, div_done, is_convert, closes_run;

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign stat.pop      = pop;
    assign stat.busy     = busy_reg;
    assign stat.div_done = div_done;

    ibcs_divider #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_acc),
        .done     (div_done),
        .quotient (quot)
    );

    // Per-axis conversion
    always_comb begin
        samp[0] = head.sample.accel_x;
        samp[1] = head.sample.accel_y;
        samp[2] = head.sample.accel_z;
        samp[3] = head.sample.gyro_x;
        samp[4] = head.sample.gyro_y;
        samp[5] = head.sample.gyro_z;
        for (int i = 0; i < AXES; i++) begin
            corr[i] = (output_form == ibcs_pkg::FORM_RAW) ? CORR_W'(samp[i])
                    : CORR_W'(samp[i]) - CORR_W'(bias_reg[i]);
            case (output_form)
                ibcs_pkg::FORM_RAW, ibcs_pkg::FORM_CORRECTED: begin
                    conv[i] = RES_W'(corr[i]);
                end
                default: begin
                    if (i < 3) begin
                        conv[i] = RES_W'(corr[i]) <<< (3'(accel_range) + 3'd1);
                    end else begin
                        conv[i] = (RES_W'(corr[i]) * ibcs_pkg::GYRO_DPS_LSB)
                                  <<< gyro_range;
                    end
                end
            endcase
            sum_acc[i] = head.accumulate ? sum_reg[i] + SUM_W'(samp[i]) : sum_reg[i];
        end
    end

    always_comb begin
        pop        = head_valid && !busy_reg && (!m_valid_reg || m_ready);
        is_convert = (head.sample.action == ibcs_pkg::ACT_CONVERT);
        closes_run = (head.sample.action == ibcs_pkg::ACT_CALIBRATE) && head.finish;
        sum_next   = sum_reg;
        bias_next  = bias_reg;
        busy_next  = busy_reg;
        div_start  = 1'b0;

        if (div_done) begin
            bias_next = quot;
            bias_next[2] = quot[2] - (ibcs_pkg::ONE_G_COUNTS >> accel_range);
            busy_next = 1'b0;
        end else if (pop) begin
            case (head.sample.action)
                ibcs_pkg::ACT_CALIBRATE: begin
                    if (head.finish) begin
                        for (int i = 0; i < AXES; i++) begin
                            sum_next[i] = '0;
                        end
                        div_start = 1'b1;
                        busy_next = 1'b1;
                    end else begin
                        sum_next = sum_acc;
                    end
                end
                ibcs_pkg::ACT_LOAD: begin
                    for (int i = 0; i < AXES; i++) begin
                        bias_next[i] = BIAS_W'(samp[i]);
                    end
                end
                default: begin
                end
            endcase
        end

        for (int i = 0; i < AXES; i++) begin
            res_val[i] = (is_convert && !div_done) ? conv[i] : RES_W'(bias_next[i]);
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (div_done || (pop && !closes_run)) begin
            m_valid_next           = 1'b1;
            m_data_next.out_accel_x = res_val[0];
            m_data_next.out_accel_y = res_val[1];
            m_data_next.out_accel_z = res_val[2];
            m_data_next.out_gyro_x  = res_val[3];
            m_data_next.out_gyro_y  = res_val[4];
            m_data_next.out_gyro_z  = res_val[5];
            m_data_next.cal_done    = div_done;
            // the closing sample always ends the run
            m_data_next.cal_active  = div_done ? 1'b0 : head.active_after;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                sum_reg[i]  <= '0;
                bias_reg[i] <= '0;
            end
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            sum_reg     <= sum_next;
            bias_reg    <= bias_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

// ===== design/imu_bias_calibrate_and_scale.sv =====
// ---------------------------------------------------------------------------
// imu_bias_calibrate_and_scale
// Six-axis IMU sample conversion with averaging bias calibration.
// ---------------------------------------------------------------------------
// Each transfer on the s_ channel carries one accel/gyro sample and an action:
// convert returns raw counts, bias-corrected counts or Q.15 g / deg/s values
// per output_form; calibrate feeds a run that drops SKIP_SAMPLES samples, sums
// the next CAL_SAMPLES per axis and then sets each bias to the truncated mean
// (accel z also lowered by one g); load sets the biases, read returns them.
// Every input gives exactly one m_ transfer. The block takes one item per
// clock while the queue has room: the front end classifies items into a
// QUEUE_DEPTH-entry queue (4 by default), the back end executes one per cycle
// from the queue head into the output register unless it is busy or a result
// waits for m_ready. The sample that closes a calibration run holds the back
// end busy until the two-stage reciprocal multiply that divides the six sums
// by CAL_SAMPLES is done; the queue keeps taking items meanwhile as long as
// it has room.
// APB map: 0x0 accel_range, 0x4 gyro_range, 0x8 output_form, bits [1:0].
// ---------------------------------------------------------------------------
`include "imu_bias_calibrate_and_scale_defines.svh"

module imu_bias_calibrate_and_scale #(
    parameter int SKIP_SAMPLES = ibcs_pkg::DEF_SKIP_SAMPLES,
    parameter int CAL_SAMPLES  = ibcs_pkg::DEF_CAL_SAMPLES,
    parameter int QUEUE_DEPTH  = ibcs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // sample input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ibcs_pkg::sample_t           s_data,
    // result output
    output logic                        m_valid,
    input  logic                        m_ready,
    output ibcs_pkg::result_t           m_data,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ibcs_pkg::ADDR_W-1:0] paddr,
    input  logic [ibcs_pkg::DATA_W-1:0] pwdata,
    output logic [ibcs_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    logic [1:0]           accel_range_reg, gyro_range_reg, output_form_reg;
    logic [1:0]           reg_idx;
    logic                 cfg_wr;

    logic                 q_not_full, q_wr_en, q_rd_valid;
    ibcs_pkg::entry_t     q_wr_data, q_rd_data;
    ibcs_pkg::back_stat_t back_stat;

    // -----------------------------------------------------------------------
    // Configuration registers; zero wait states
    // -----------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ibcs_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_range_reg <= 2'd0;
            gyro_range_reg  <= 2'd0;
            output_form_reg <= ibcs_pkg::FORM_CORRECTED;
        end else if (cfg_wr) begin
            case (reg_idx)
                ibcs_pkg::REG_ACCEL_RANGE: accel_range_reg <= pwdata[1:0];
                ibcs_pkg::REG_GYRO_RANGE:  gyro_range_reg  <= pwdata[1:0];
                ibcs_pkg::REG_OUTPUT_FORM: output_form_reg <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ibcs_pkg::REG_ACCEL_RANGE: prdata = ibcs_pkg::DATA_W'(accel_range_reg);
            ibcs_pkg::REG_GYRO_RANGE:  prdata = ibcs_pkg::DATA_W'(gyro_range_reg);
            ibcs_pkg::REG_OUTPUT_FORM: prdata = ibcs_pkg::DATA_W'(output_form_reg);
            default:                   prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Front end: accept and classify, tracks the calibration count
    // -----------------------------------------------------------------------
    ibcs_front #(
        .SKIP_SAMPLES (SKIP_SAMPLES),
        .CAL_SAMPLES  (CAL_SAMPLES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_not_full (q_not_full),
        .q_wr_en    (q_wr_en),
        .q_wr_data  (q_wr_data)
    );

    // -----------------------------------------------------------------------
    // Queue decouples the front from a stalled back end
    // -----------------------------------------------------------------------
    ibcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .not_full (q_not_full),
        .rd_en    (back_stat.pop),
        .rd_valid (q_rd_valid),
        .rd_data  (q_rd_data)
    );

    // -----------------------------------------------------------------------
    // Back end: sums, biases, conversion and output register
    // -----------------------------------------------------------------------
    ibcs_back #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accel_range (accel_range_reg),
        .gyro_range  (gyro_range_reg),
        .output_form (output_form_reg),
        .head_valid  (q_rd_valid),
        .head        (q_rd_data),
        .stat        (back_stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `IBCS_ASSERT(a_done_ends_run, m_valid && m_data.cal_done |-> !m_data.cal_active, "cal_done with run still active")
    `IBCS_ASSERT_NEVER(a_no_pop_while_div, back_stat.busy && back_stat.pop, "queue popped during division")
    `IBCS_ASSERT(a_slot_free_at_div_done, back_stat.div_done |-> !m_valid, "output busy when biases finish")
    `IBCS_ASSERT(a_done_result_follows, back_stat.div_done |=> m_valid && m_data.cal_done, "missing cal_done transfer")

endmodule
